FILE: rtl/core/lsnh_pkg.sv
// ----------------------------------------------------------------------------
// lsnh_pkg: shared types and constants of the link-state next-hop engine
// Router count, id widths, controller states and the command/status structs.
// ----------------------------------------------------------------------------
package lsnh_pkg;

    localparam int NumRouters = 16;
    localparam int IdW        = 4;
    localparam int TabDepth   = NumRouters * NumRouters;
    localparam int TabAw      = 2 * IdW;

    localparam logic CmdUpdate = 1'b0;
    localparam logic CmdQuery  = 1'b1;

    typedef logic [NumRouters-1:0] t_mask;
    typedef logic [IdW-1:0]        t_id;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE,
        ST_SEED,
        ST_LEVEL,
        ST_WRITE,
        ST_QREAD,
        ST_RESP
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic capture;     // latch the accepted beat
        logic edge_upd;    // rewrite the announcing router's edges
        logic seed;        // start a search from the current destination
        logic level;       // expand one breadth-first level
        logic write_row;   // store one table entry, advance the row counter
        logic next_dest;   // advance to the next destination
        logic qread;       // launch the table read for a query
        logic load_resp;   // load the output register
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic frontier_empty;
        logic row_last;
        logic dest_last;
        logic is_query;
        logic accept_upd;  // update command with central mode enabled
    } t_status;

endpackage

FILE: rtl/core/link_state_next_hop_engine_top.sv
// ----------------------------------------------------------------------------
// link_state_next_hop_engine_top: central link-state route computer
// Holds the network graph and a full next-hop table; answers route queries.
// ----------------------------------------------------------------------------
// An update beat names a router and its neighbor mask; the block rewrites
// that router's undirected edges and then rebuilds the whole next-hop table
// by a breadth-first search from each of the sixteen destinations, one level
// per cycle and one table entry per cycle. An update that is ignored because
// central mode is off skips the rebuild. A query goes through one read of the
// table memory. Exactly one result beat follows each input beat: resp_kind
// tells an update acknowledge from a query answer, and next_hop is zero
// whenever found is low. When central mode is off, updates change nothing
// and queries answer not found. Only one beat is in flight; the result sits
// in an output register until the sink takes it.
// ----------------------------------------------------------------------------
module link_state_next_hop_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [3:0]  i_router_id,
    input  logic [15:0] i_neighbor_mask,
    input  logic [3:0]  i_dest_id,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_resp_kind,
    output logic [3:0]  o_next_hop,
    output logic        o_found
);

    logic              r_enable;
    logic              r_out_valid;
    logic              in_ready, in_fire, out_free;
    lsnh_pkg::t_cmd    cmd;
    lsnh_pkg::t_status status;

    // Mode register: reset enables central mode.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_wdata;
        end
    end

    assign o_in_stall = !in_ready;
    assign in_fire    = i_in_valid && in_ready;
    // The output register may be reloaded once the previous beat is gone.
    assign out_free   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.load_resp) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end
    assign o_out_valid = r_out_valid;

    lsnh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_out_free (out_free),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    lsnh_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_enable        (r_enable),
        .i_cmd_bit       (i_cmd),
        .i_router_id     (i_router_id),
        .i_neighbor_mask (i_neighbor_mask),
        .i_dest_id       (i_dest_id),
        .o_status        (status),
        .o_resp_kind     (o_resp_kind),
        .o_next_hop      (o_next_hop),
        .o_found         (o_found)
    );

endmodule

FILE: rtl/core/lsnh_ctrl.sv
// ----------------------------------------------------------------------------
// lsnh_ctrl: sequencer of the link-state next-hop engine
// Steps an update through the edge rewrite and sixteen searches, or a query
// through one table read, and hands the result to the output register.
// ----------------------------------------------------------------------------
module lsnh_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_fire,
    input  logic               i_out_free,
    input  lsnh_pkg::t_status  i_status,
    output lsnh_pkg::t_cmd     o_cmd,
    output logic               o_in_ready
);

    lsnh_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsnh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lsnh_pkg::ST_IDLE: begin
                if (i_in_fire) begin
                    n_state = lsnh_pkg::ST_EDGE;
                end
            end
            lsnh_pkg::ST_EDGE: begin
                if (i_status.is_query) begin
                    n_state = lsnh_pkg::ST_QREAD;
                end else if (i_status.accept_upd) begin
                    n_state = lsnh_pkg::ST_SEED;
                end else begin
                    n_state = lsnh_pkg::ST_RESP;
                end
            end
            lsnh_pkg::ST_SEED:  n_state = lsnh_pkg::ST_LEVEL;
            lsnh_pkg::ST_LEVEL: begin
                if (i_status.frontier_empty) begin
                    n_state = lsnh_pkg::ST_WRITE;
                end
            end
            lsnh_pkg::ST_WRITE: begin
                if (i_status.row_last) begin
                    n_state = i_status.dest_last ? lsnh_pkg::ST_RESP : lsnh_pkg::ST_SEED;
                end
            end
            lsnh_pkg::ST_QREAD: n_state = lsnh_pkg::ST_RESP;
            lsnh_pkg::ST_RESP: begin
                if (i_out_free) begin
                    n_state = lsnh_pkg::ST_IDLE;
                end
            end
            default: n_state = lsnh_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            lsnh_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_fire;
            end
            lsnh_pkg::ST_EDGE: o_cmd.edge_upd = i_status.accept_upd;
            lsnh_pkg::ST_SEED: o_cmd.seed = 1'b1;
            lsnh_pkg::ST_LEVEL: o_cmd.level = !i_status.frontier_empty;
            lsnh_pkg::ST_WRITE: begin
                o_cmd.write_row = 1'b1;
                o_cmd.next_dest = i_status.row_last;
            end
            lsnh_pkg::ST_QREAD: o_cmd.qread = 1'b1;
            lsnh_pkg::ST_RESP: o_cmd.load_resp = i_out_free;
            default: o_cmd = '0;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |-> o_in_ready)
        else $error("capture outside idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_resp |=> o_in_ready)
        else $error("response did not return to idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.seed |=> r_state == lsnh_pkg::ST_LEVEL)
        else $error("seed not followed by search");

endmodule

FILE: rtl/core/lsnh_dp.sv
// ----------------------------------------------------------------------------
// lsnh_dp: datapath of the link-state next-hop engine
// Adjacency matrix, breadth-first search registers, predecessor registers
// and the next-hop table memory with its valid bits.
// ----------------------------------------------------------------------------
module lsnh_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lsnh_pkg::t_cmd      i_cmd,
    input  logic                i_enable,
    input  logic                i_cmd_bit,
    input  logic [3:0]          i_router_id,
    input  logic [15:0]         i_neighbor_mask,
    input  logic [3:0]          i_dest_id,
    output lsnh_pkg::t_status   o_status,
    output logic                o_resp_kind,
    output logic [3:0]          o_next_hop,
    output logic                o_found
);

    localparam int N = lsnh_pkg::NumRouters;

    logic                 r_cmd;
    lsnh_pkg::t_id        r_rid, r_did;
    lsnh_pkg::t_mask      r_mask;
    logic                 r_en;
    lsnh_pkg::t_mask      r_adj [N];
    lsnh_pkg::t_mask      r_known;
    lsnh_pkg::t_mask      r_visited, r_frontier;
    lsnh_pkg::t_id        r_pred [N];
    lsnh_pkg::t_id        r_dest, r_row;
    logic [lsnh_pkg::TabDepth-1:0] r_valid;
    lsnh_pkg::t_id        r_mem [lsnh_pkg::TabDepth];
    lsnh_pkg::t_id        r_rd_hop;
    logic                 r_rd_ok;

    lsnh_pkg::t_mask      reached;
    lsnh_pkg::t_mask      self_bit, clean_mask;
    lsnh_pkg::t_id        pick [N];
    logic [lsnh_pkg::TabAw-1:0] wr_addr, rd_addr;
    logic                 wr_valid;

    assign self_bit   = lsnh_pkg::t_mask'(1) << r_rid;
    assign clean_mask = r_mask & ~self_bit;

    // One level of the search: routers adjacent to the frontier, not visited.
    always_comb begin
        reached = '0;
        for (int v = 0; v < N; v++) begin
            if (r_frontier[v]) begin
                reached = reached | r_adj[v];
            end
        end
        reached = reached & ~r_visited;
    end

    // Lowest-numbered frontier neighbor of each router.
    always_comb begin
        lsnh_pkg::t_mask hit;
        for (int v = 0; v < N; v++) begin
            hit = r_adj[v] & r_frontier;
            pick[v] = '0;
            for (int u = N - 1; u >= 0; u--) begin
                if (hit[u]) begin
                    pick[v] = lsnh_pkg::t_id'(u);
                end
            end
        end
    end

    assign o_status.frontier_empty = (r_frontier == '0);
    assign o_status.row_last       = (r_row == lsnh_pkg::t_id'(N - 1));
    assign o_status.dest_last      = (r_dest == lsnh_pkg::t_id'(N - 1));
    assign o_status.is_query       = (r_cmd == lsnh_pkg::CmdQuery);
    assign o_status.accept_upd     = r_en && (r_cmd == lsnh_pkg::CmdUpdate);

    assign wr_addr  = {r_row, r_dest};
    assign rd_addr  = {r_rid, r_did};
    assign wr_valid = (r_row != r_dest) && r_visited[r_row];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd  <= i_cmd_bit;
            r_rid  <= i_router_id;
            r_mask <= i_neighbor_mask;
            r_did  <= i_dest_id;
            r_en   <= i_enable;
        end
        if (i_cmd.level) begin
            for (int v = 0; v < N; v++) begin
                if (reached[v]) begin
                    r_pred[v] <= pick[v];
                end
            end
        end
        if (i_cmd.write_row) begin
            r_mem[wr_addr] <= r_pred[r_row];
        end
        if (i_cmd.qread) begin
            r_rd_hop <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) begin
                r_adj[k] <= '0;
            end
            r_known    <= '0;
            r_visited  <= '0;
            r_frontier <= '0;
            r_dest     <= '0;
            r_row      <= '0;
            r_valid    <= '0;
            r_rd_ok    <= 1'b0;
            o_resp_kind <= 1'b0;
            o_next_hop  <= '0;
            o_found     <= 1'b0;
        end else begin
            if (i_cmd.edge_upd) begin
                r_known <= r_known | self_bit | clean_mask;
                for (int k = 0; k < N; k++) begin
                    if (lsnh_pkg::t_id'(k) == r_rid) begin
                        r_adj[k] <= clean_mask;
                    end else begin
                        r_adj[k] <= (r_adj[k] & ~self_bit) | (clean_mask[k] ? self_bit : '0);
                    end
                end
                r_dest <= '0;
                r_row  <= '0;
            end
            if (i_cmd.seed) begin
                r_visited  <= lsnh_pkg::t_mask'(1) << r_dest;
                r_frontier <= lsnh_pkg::t_mask'(1) << r_dest;
            end
            if (i_cmd.level) begin
                r_visited  <= r_visited | reached;
                r_frontier <= reached;
            end
            if (i_cmd.write_row) begin
                r_valid[wr_addr] <= wr_valid;
                r_row <= r_row + 1'b1;
            end
            if (i_cmd.next_dest) begin
                r_dest <= r_dest + 1'b1;
            end
            if (i_cmd.qread) begin
                r_rd_ok <= r_en && r_valid[rd_addr];
            end
            if (i_cmd.load_resp) begin
                o_resp_kind <= r_cmd;
                o_found     <= o_status.is_query && r_rd_ok;
                o_next_hop  <= (o_status.is_query && r_rd_ok) ? r_rd_hop : '0;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.seed |=> $onehot(r_frontier))
        else $error("search seed is not a single router");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.level |=> (r_frontier & ~r_visited) == '0)
        else $error("frontier escaped the visited set");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_resp && !o_status.is_query |=> !o_found && o_next_hop == '0)
        else $error("update result carries a route");

endmodule
